[rtl/sync_frame_parser_macros.svh]
// Assertion macros for the sync frame parser.
// Used by sync_frame_parser.sv; each macro expects clk and rst_n in scope.
`ifndef SYNC_FRAME_PARSER_MACROS_SVH
`define SYNC_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sfp_pkg.sv]
// Shared types and constants for the sync frame parser.
// No dependencies; used by sync_frame_parser.sv.
package sfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LENH  = 3'd3,
    PH_LENL  = 3'd4,
    PH_DATA  = 3'd5,
    PH_CHECK = 3'd6
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    STATUS_NONE = 2'd0,
    STATUS_GOOD = 2'd1,
    STATUS_BAD  = 2'd2
  } status_t;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH  = 2'd2;

  localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [LenW-1:0]  MAX_LENGTH_RST  = 16'd256;

endpackage

[rtl/sync_frame_parser.sv]
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the phase register and the result register
// update together, and a new byte is taken whenever the result register is
// empty or is being read in the same cycle.
// Reset (synchronous, active low) returns to hunting the first sync byte and
// restores the configuration registers to their defaults.
// Top level of the sync frame parser: header hunt, length check and XOR check.
// Depends on sfp_pkg.sv and sync_frame_parser_macros.svh.
`include "sync_frame_parser_macros.svh"

module sync_frame_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sfp_pkg::CfgW-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sfp_pkg::ByteW-1:0]     in_data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfp_pkg::StatusW-1:0]   out_frame_status,
  output logic [sfp_pkg::ByteW-1:0]     out_command,
  output logic [sfp_pkg::LenW-1:0]      out_length,
  output logic                          out_payload_valid,
  output logic [sfp_pkg::ByteW-1:0]     out_payload_byte,
  output logic [sfp_pkg::LenW-1:0]      out_payload_index,
  output logic [sfp_pkg::ByteW-1:0]     out_received_check
);

  logic [sfp_pkg::ByteW-1:0] sync_first_r;
  logic [sfp_pkg::ByteW-1:0] sync_second_r;
  logic [sfp_pkg::LenW-1:0]  max_length_r;

  sfp_pkg::phase_t           phase_r, phase_nxt;
  logic [sfp_pkg::ByteW-1:0] command_r, command_nxt;
  logic [sfp_pkg::LenW-1:0]  length_r, length_nxt;
  logic [sfp_pkg::LenW-1:0]  count_r, count_nxt;
  logic [sfp_pkg::ByteW-1:0] xor_r, xor_nxt;

  logic                        out_valid_r;
  sfp_pkg::status_t            status_r, status_nxt;
  logic                        pvalid_r, pvalid_nxt;
  logic [sfp_pkg::ByteW-1:0]   pbyte_r, pbyte_nxt;
  logic [sfp_pkg::LenW-1:0]    pindex_r, pindex_nxt;
  logic [sfp_pkg::ByteW-1:0]   rcheck_r, rcheck_nxt;

  logic                        in_fire;
  logic [sfp_pkg::LenW-1:0]    full_length;
  logic [sfp_pkg::LenW-1:0]    count_inc;

  assign in_ready    = !out_valid_r || out_ready;
  assign in_fire     = in_valid && in_ready;
  assign full_length = {length_r[sfp_pkg::LenW-1:sfp_pkg::ByteW], in_data_byte};
  assign count_inc   = count_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= sfp_pkg::SYNC_FIRST_RST;
      sync_second_r <= sfp_pkg::SYNC_SECOND_RST;
      max_length_r  <= sfp_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfp_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata[sfp_pkg::ByteW-1:0];
        sfp_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata[sfp_pkg::ByteW-1:0];
        sfp_pkg::CFG_MAX_LENGTH:  max_length_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = sfp_pkg::PH_IDLE;
    unique case (phase_r)
      sfp_pkg::PH_SYNC2: begin
        phase_nxt = (in_data_byte == sync_second_r) ? sfp_pkg::PH_CMD : sfp_pkg::PH_IDLE;
      end
      sfp_pkg::PH_CMD:  phase_nxt = sfp_pkg::PH_LENH;
      sfp_pkg::PH_LENH: phase_nxt = sfp_pkg::PH_LENL;
      sfp_pkg::PH_LENL: begin
        priority if (full_length > max_length_r) begin
          phase_nxt = sfp_pkg::PH_IDLE;
        end else if (full_length == '0) begin
          phase_nxt = sfp_pkg::PH_CHECK;
        end else begin
          phase_nxt = sfp_pkg::PH_DATA;
        end
      end
      sfp_pkg::PH_DATA: begin
        phase_nxt = (count_inc >= length_r) ? sfp_pkg::PH_CHECK : sfp_pkg::PH_DATA;
      end
      sfp_pkg::PH_CHECK: phase_nxt = sfp_pkg::PH_IDLE;
      default: begin
        phase_nxt = (in_data_byte == sync_first_r) ? sfp_pkg::PH_SYNC2 : sfp_pkg::PH_IDLE;
      end
    endcase
  end

  // Frame state and result values.
  always_comb begin
    command_nxt = command_r;
    length_nxt  = length_r;
    count_nxt   = count_r;
    xor_nxt     = xor_r;
    status_nxt  = sfp_pkg::STATUS_NONE;
    pvalid_nxt  = 1'b0;
    pbyte_nxt   = '0;
    pindex_nxt  = '0;
    rcheck_nxt  = '0;
    unique case (phase_r)
      sfp_pkg::PH_CMD: begin
        command_nxt = in_data_byte;
        xor_nxt     = in_data_byte;
      end
      sfp_pkg::PH_LENH: begin
        length_nxt = {in_data_byte, 8'h00};
        xor_nxt    = xor_r ^ in_data_byte;
      end
      sfp_pkg::PH_LENL: begin
        length_nxt = full_length;
        xor_nxt    = xor_r ^ in_data_byte;
        count_nxt  = '0;
      end
      sfp_pkg::PH_DATA: begin
        pvalid_nxt = 1'b1;
        pbyte_nxt  = in_data_byte;
        pindex_nxt = count_r;
        xor_nxt    = xor_r ^ in_data_byte;
        count_nxt  = count_inc;
      end
      sfp_pkg::PH_CHECK: begin
        rcheck_nxt = in_data_byte;
        status_nxt = (in_data_byte == xor_r) ? sfp_pkg::STATUS_GOOD : sfp_pkg::STATUS_BAD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sfp_pkg::PH_IDLE;
      command_r   <= '0;
      length_r    <= '0;
      count_r     <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r   <= phase_nxt;
        command_r <= command_nxt;
        length_r  <= length_nxt;
        count_r   <= count_nxt;
        xor_r     <= xor_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      pvalid_r <= pvalid_nxt;
      pbyte_r  <= pbyte_nxt;
      pindex_r <= pindex_nxt;
      rcheck_r <= rcheck_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_status   = status_r;
  assign out_command        = command_r;
  assign out_length         = length_r;
  assign out_payload_valid  = pvalid_r;
  assign out_payload_byte   = pbyte_r;
  assign out_payload_index  = pindex_r;
  assign out_received_check = rcheck_r;

  `SFP_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_r, "Accepted byte produced no result.")
  `SFP_ASSERT_NOW(a_payload_no_status, out_valid_r && pvalid_r,
    status_r == sfp_pkg::STATUS_NONE, "Payload result carries a frame status.")
  `SFP_ASSERT_NOW(a_status_ends_frame, out_valid_r && (status_r != sfp_pkg::STATUS_NONE),
    phase_r == sfp_pkg::PH_IDLE, "Checksum result without return to idle.")
  `SFP_ASSERT_NOW(a_count_in_range, phase_r == sfp_pkg::PH_DATA,
    count_r < length_r, "Payload count reached the frame length inside the payload.")
  `SFP_ASSERT_NOW(a_payload_phase, out_valid_r && pvalid_r,
    (phase_r == sfp_pkg::PH_DATA) || (phase_r == sfp_pkg::PH_CHECK),
    "Payload result outside the payload phase.")

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for sync_frame_parser: frames, broken headers, oversized lengths and noise.
// Depends on sfp_pkg.sv and the sync_frame_parser RTL; predicts every result internally.
module testbench;

  typedef struct {
    sfp_pkg::status_t          status;
    logic [sfp_pkg::ByteW-1:0] command;
    logic [sfp_pkg::LenW-1:0]  length;
    logic                      pvalid;
    logic [sfp_pkg::ByteW-1:0] pbyte;
    logic [sfp_pkg::LenW-1:0]  pindex;
    logic [sfp_pkg::ByteW-1:0] rcheck;
  } parse_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [sfp_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [sfp_pkg::CfgW-1:0]    cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [sfp_pkg::ByteW-1:0]   in_data_byte = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [sfp_pkg::StatusW-1:0] out_frame_status;
  logic [sfp_pkg::ByteW-1:0]   out_command;
  logic [sfp_pkg::LenW-1:0]    out_length;
  logic                        out_payload_valid;
  logic [sfp_pkg::ByteW-1:0]   out_payload_byte;
  logic [sfp_pkg::LenW-1:0]    out_payload_index;
  logic [sfp_pkg::ByteW-1:0]   out_received_check;

  sfp_pkg::phase_t           model_phase;
  logic [sfp_pkg::ByteW-1:0] model_cmd;
  logic [sfp_pkg::LenW-1:0]  model_len;
  logic [sfp_pkg::LenW-1:0]  model_count;
  logic [sfp_pkg::ByteW-1:0] model_xor;
  logic [sfp_pkg::ByteW-1:0] model_sync_first;
  logic [sfp_pkg::ByteW-1:0] model_sync_second;
  logic [sfp_pkg::LenW-1:0]  model_max_length;

  parse_result_t pending_results[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  sync_frame_parser DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_status(out_frame_status), .out_command(out_command),
    .out_length(out_length), .out_payload_valid(out_payload_valid),
    .out_payload_byte(out_payload_byte), .out_payload_index(out_payload_index),
    .out_received_check(out_received_check)
  );

  always #5 clk = ~clk;

  function automatic void reset_parser_model();
    model_phase       = sfp_pkg::PH_IDLE;
    model_cmd         = '0;
    model_len         = '0;
    model_count       = '0;
    model_xor         = '0;
    model_sync_first  = sfp_pkg::SYNC_FIRST_RST;
    model_sync_second = sfp_pkg::SYNC_SECOND_RST;
    model_max_length  = sfp_pkg::MAX_LENGTH_RST;
  endfunction

  function automatic void advance_parser(input logic [sfp_pkg::ByteW-1:0] b);
    parse_result_t r;
    r.status = sfp_pkg::STATUS_NONE;
    r.pvalid = 1'b0;
    r.pbyte  = '0;
    r.pindex = '0;
    r.rcheck = '0;
    case (model_phase)
      sfp_pkg::PH_SYNC2: begin
        model_phase = (b == model_sync_second) ? sfp_pkg::PH_CMD : sfp_pkg::PH_IDLE;
      end
      sfp_pkg::PH_CMD: begin
        model_cmd   = b;
        model_xor   = b;
        model_phase = sfp_pkg::PH_LENH;
      end
      sfp_pkg::PH_LENH: begin
        model_len   = {b, 8'h00};
        model_xor   = model_xor ^ b;
        model_phase = sfp_pkg::PH_LENL;
      end
      sfp_pkg::PH_LENL: begin
        model_len[7:0] = b;
        model_xor      = model_xor ^ b;
        model_count    = '0;
        if (model_len > model_max_length) model_phase = sfp_pkg::PH_IDLE;
        else if (model_len == '0) model_phase = sfp_pkg::PH_CHECK;
        else model_phase = sfp_pkg::PH_DATA;
      end
      sfp_pkg::PH_DATA: begin
        r.pvalid    = 1'b1;
        r.pbyte     = b;
        r.pindex    = model_count;
        model_xor   = model_xor ^ b;
        model_count = model_count + 1'b1;
        if (model_count >= model_len) model_phase = sfp_pkg::PH_CHECK;
      end
      sfp_pkg::PH_CHECK: begin
        r.rcheck    = b;
        r.status    = (b == model_xor) ? sfp_pkg::STATUS_GOOD : sfp_pkg::STATUS_BAD;
        model_phase = sfp_pkg::PH_IDLE;
      end
      default: begin
        model_phase = (b == model_sync_first) ? sfp_pkg::PH_SYNC2 : sfp_pkg::PH_IDLE;
      end
    endcase
    r.command = model_cmd;
    r.length  = model_len;
    pending_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Outputs are stable between the falling edge and the next rising edge,
  // so a transaction seen here completes at that rising edge.
  always @(negedge clk) begin
    parse_result_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no transaction pending", $time);
      end else begin
        exp = pending_results.pop_front();
        if (out_frame_status !== exp.status || out_command !== exp.command ||
            out_length !== exp.length || out_payload_valid !== exp.pvalid ||
            out_payload_byte !== exp.pbyte || out_payload_index !== exp.pindex ||
            out_received_check !== exp.rcheck) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected st=%0d cmd=%h len=%h pv=%b pb=%h pi=%h chk=%h", $time,
                     exp.status, exp.command, exp.length, exp.pvalid, exp.pbyte,
                     exp.pindex, exp.rcheck);
            $display("%0t:      got st=%0d cmd=%h len=%h pv=%b pb=%h pi=%h chk=%h", $time,
                     out_frame_status, out_command, out_length, out_payload_valid,
                     out_payload_byte, out_payload_index, out_received_check);
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [sfp_pkg::ByteW-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    advance_parser(b);
    bytes_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_register(input logic [sfp_pkg::CfgIdxW-1:0] idx,
                              input logic [sfp_pkg::CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      sfp_pkg::CFG_SYNC_FIRST:  model_sync_first = val[sfp_pkg::ByteW-1:0];
      sfp_pkg::CFG_SYNC_SECOND: model_sync_second = val[sfp_pkg::ByteW-1:0];
      sfp_pkg::CFG_MAX_LENGTH:  model_max_length = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [sfp_pkg::ByteW-1:0] s1,
                           input logic [sfp_pkg::ByteW-1:0] s2,
                           input logic [sfp_pkg::LenW-1:0] max_len);
    set_register(sfp_pkg::CFG_SYNC_FIRST, {8'($urandom_range(0, 255)), s1});
    set_register(sfp_pkg::CFG_SYNC_SECOND, {8'($urandom_range(0, 255)), s2});
    set_register(sfp_pkg::CFG_MAX_LENGTH, max_len);
  endtask

  // Oversized frames stop after the length, since the parser drops them there.
  task automatic send_frame(input logic [sfp_pkg::ByteW-1:0] cmd,
                            input logic [sfp_pkg::LenW-1:0] len, input bit corrupt);
    logic [sfp_pkg::ByteW-1:0] sum;
    logic [sfp_pkg::ByteW-1:0] b;
    send_byte(model_sync_first);
    send_byte(model_sync_second);
    send_byte(cmd);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (len <= model_max_length) begin
      sum = cmd ^ len[15:8] ^ len[7:0];
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        sum = sum ^ b;
        send_byte(b);
      end
      if (corrupt) sum = sum ^ 8'(1 << $urandom_range(0, 7));
      send_byte(sum);
    end
  endtask

  task automatic reset_block();
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    reset_parser_model();
    @(posedge clk);
  endtask

  task automatic test_directed_frames();
    send_frame(8'h00, 16'd0, 1'b0);
    send_frame(8'hFF, 16'd2, 1'b1);
    send_byte(model_sync_first);
    send_byte(model_sync_first);
    send_byte(model_sync_second);
    send_frame(8'h01, 16'h0101, 1'b0);
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    configure(8'h00, 8'hFF, 16'd0);
    send_frame(8'h5A, 16'd0, 1'b0);
    send_frame(8'hA5, 16'd1, 1'b0);
    wait_for_results();
    configure(8'hFF, 8'h00, 16'hFFFF);
    send_frame(8'h3C, 16'd3, 1'b0);
    wait_for_results();
    configure(sfp_pkg::SYNC_FIRST_RST, sfp_pkg::SYNC_SECOND_RST, 16'd4);
    send_frame(8'hC3, 16'd4, 1'b0);
    send_frame(8'h81, 16'd5, 1'b0);
    send_frame(8'h7E, 16'hFFFF, 1'b0);
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    int saved_idle;
    saved_idle = send_idle_pct;
    configure(sfp_pkg::SYNC_FIRST_RST, sfp_pkg::SYNC_SECOND_RST, sfp_pkg::MAX_LENGTH_RST);
    send_idle_pct = 0;
    hold_cycles = 120;
    send_frame(8'h42, 16'd20, 1'b0);
    wait_for_results();
    send_idle_pct = saved_idle;
  endtask

  task automatic test_random_traffic(input int count);
    int stop_at;
    int kind;
    int lim;
    logic [sfp_pkg::LenW-1:0] len;
    logic [sfp_pkg::ByteW-1:0] b;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      lim = (model_max_length < 12) ? model_max_length : 12;
      if (kind <= 6) begin
        len = 16'($urandom_range(0, lim));
        if (model_max_length <= 64 && $urandom_range(0, 15) == 0) len = model_max_length;
        send_frame(8'($urandom_range(0, 255)), len, $urandom_range(0, 3) == 0);
      end else if (kind == 7 && model_max_length != 16'hFFFF) begin
        len = 16'($urandom_range(model_max_length + 1, 65535));
        send_frame(8'($urandom_range(0, 255)), len, 1'b0);
      end else if (kind == 8) begin
        send_byte(model_sync_first);
        if ($urandom_range(0, 1) == 0) begin
          do b = 8'($urandom_range(0, 255)); while (b == model_sync_second);
          send_byte(b);
        end else begin
          send_byte(model_sync_second);
          send_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    wait_for_results();
  endtask

  initial begin
    reset_block();
    send_idle_pct = 11;
    recv_idle_pct = 71;
    test_directed_frames();
    test_register_extremes();
    test_output_backpressure();
    configure(sfp_pkg::SYNC_FIRST_RST, sfp_pkg::SYNC_SECOND_RST, 16'd8);
    test_random_traffic(330);
    send_idle_pct = 71;
    recv_idle_pct = 11;
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 40)));
    test_random_traffic(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(sfp_pkg::SYNC_FIRST_RST, sfp_pkg::SYNC_SECOND_RST, 16'hFFFF);
    test_random_traffic(330);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/sfp_pkg.sv
rtl/sync_frame_parser.sv
bench/testbench.sv
